### hw/rtl/icset_pkg.sv
// ----------------------------------------------------------------------------
// icset_pkg
// Shared types and defaults for the interval coverage set block.
// ----------------------------------------------------------------------------
package icset_pkg;

  // default sizes
  localparam int unsigned DefMaxEntries   = 16;
  localparam int unsigned DefPositionBits = 48;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_PROBE = 2'd1,
    OP_GAPS  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;       // capture the input word, begin the table walk
    logic walk;        // perform one step of the walk
    logic commit;      // update the committed table state
    logic emit_final;  // load the closing result word
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic walk_done;     // walk has covered the table
    logic final_needed;  // a closing result word follows the walk
    logic out_free;      // output register can take a word this cycle
  } status_t;

endpackage

### hw/rtl/interval_coverage_set_unit.sv
// ----------------------------------------------------------------------------
// interval_coverage_set_unit
// Sorted table of disjoint half-open intervals with add, probe, gap listing
// and clear operations.
// ----------------------------------------------------------------------------
// Usage: one word on s_axis carries an operation in tuser (add, probe, list
// gaps, clear) and the positions in tdata. Each word yields one result word
// on m_axis, or one per gap for a gap listing; tlast marks the final one.
// Every result carries the covered total, entry count and table bounds.
// Timing: a walk steps through the stored entries at the RAM read port at one
// entry per cycle, save that a gap listing waits for the output register. An
// add also writes the merged interval into the other bank; a clear or a
// rejected add does not walk the entries. The entry walk over the table RAM
// sets the rate: one word at a time.
// The add writes the merged table into the other RAM bank and swaps banks on
// success, so an overflowing add leaves the table untouched.
// Reset empties the table; no clearing pass is needed. When m_axis stalls,
// the result stays in the output register while the next word is accepted;
// a gap listing pauses its walk until the result is taken.
// ----------------------------------------------------------------------------
module interval_coverage_set_unit
  import icset_pkg::*;
#(
  parameter int unsigned MaxEntries   = DefMaxEntries,
  parameter int unsigned PositionBits = DefPositionBits,
  localparam int unsigned CntW        = $clog2(MaxEntries + 1),
  localparam int unsigned InW         = ((3 * PositionBits + 7) / 8) * 8,
  localparam int unsigned OutBits     = 5 * PositionBits + CntW + 1,
  localparam int unsigned OutW        = ((OutBits + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // interval_start, interval_end, probe_position
  input  logic [InW-1:0]  s_axis_tdata,
  // operation
  input  logic [1:0]      s_axis_tuser,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // covered, total_length, entry_count, bound_start, bound_end, gap_start,
  // gap_end
  output logic [OutW-1:0] m_axis_tdata,
  // gap_valid, overflow, rejected
  output logic [2:0]      m_axis_tuser,
  output logic            m_axis_tlast
);

  localparam int unsigned Pb = PositionBits;

  cmd_t    cmd;
  status_t status;

  logic            covered, gap_valid, overflow, rejected;
  logic [Pb-1:0]   total_length, bound_start, bound_end, gap_start, gap_end;
  logic [CntW-1:0] entry_count;

  icset_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  icset_dp #(
    .MaxEntries  (MaxEntries),
    .PositionBits(PositionBits)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .op_i             (op_e'(s_axis_tuser)),
    .interval_start_i (s_axis_tdata[Pb-1:0]),
    .interval_end_i   (s_axis_tdata[2*Pb-1:Pb]),
    .probe_position_i (s_axis_tdata[3*Pb-1:2*Pb]),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .covered_o        (covered),
    .total_length_o   (total_length),
    .entry_count_o    (entry_count),
    .bound_start_o    (bound_start),
    .bound_end_o      (bound_end),
    .gap_valid_o      (gap_valid),
    .gap_start_o      (gap_start),
    .gap_end_o        (gap_end),
    .last_o           (m_axis_tlast),
    .overflow_o       (overflow),
    .rejected_o       (rejected)
  );

  // pack the result word
  assign m_axis_tdata = OutW'({gap_end, gap_start, bound_end, bound_start,
                               entry_count, total_length, covered});
  assign m_axis_tuser = {rejected, overflow, gap_valid};

endmodule

### hw/rtl/icset_ram.sv
// ----------------------------------------------------------------------------
// icset_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module icset_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/icset_ctrl.sv
// ----------------------------------------------------------------------------
// icset_ctrl
// Controller state machine: accepts a word, runs the table walk, commits and
// emits the closing result.
// ----------------------------------------------------------------------------
module icset_ctrl
  import icset_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_FIN  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.walk_done) begin
          state_d = status_i.final_needed ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        cmd_o.commit = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // only one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.start, cmd_o.walk, cmd_o.commit, cmd_o.emit_final}))
    else $error("icset_ctrl: overlapping commands");

  // a commit is always followed by the closing result stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (state_q == S_EMIT))
    else $error("icset_ctrl: commit not followed by emit");

  // a word is only taken from idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> (state_q == S_IDLE))
    else $error("icset_ctrl: start outside idle");

endmodule

### hw/rtl/icset_dp.sv
// ----------------------------------------------------------------------------
// icset_dp
// Datapath: two table banks in one RAM, walk registers, committed totals and
// the output register.
// ----------------------------------------------------------------------------
module icset_dp
  import icset_pkg::*;
#(
  parameter int unsigned MaxEntries   = DefMaxEntries,
  parameter int unsigned PositionBits = DefPositionBits,
  localparam int unsigned CntW        = $clog2(MaxEntries + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  // captured input fields
  input  op_e                     op_i,
  input  logic [PositionBits-1:0] interval_start_i,
  input  logic [PositionBits-1:0] interval_end_i,
  input  logic [PositionBits-1:0] probe_position_i,
  // result register
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic                    covered_o,
  output logic [PositionBits-1:0] total_length_o,
  output logic [CntW-1:0]         entry_count_o,
  output logic [PositionBits-1:0] bound_start_o,
  output logic [PositionBits-1:0] bound_end_o,
  output logic                    gap_valid_o,
  output logic [PositionBits-1:0] gap_start_o,
  output logic [PositionBits-1:0] gap_end_o,
  output logic                    last_o,
  output logic                    overflow_o,
  output logic                    rejected_o
);

  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned AdrW = IdxW + 1;
  localparam int unsigned EntW = 2 * PositionBits;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxEntries);

  // captured operation
  op_e                     op_q;
  logic [PositionBits-1:0] s_q, e_q, p_q;
  logic                    rej_q;

  // committed table state
  logic                    bank_q, bank_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [PositionBits-1:0] total_q, total_d, bs_q, bs_d, be_q, be_d;

  // walk state
  logic [CntW-1:0]         idx_q, idx_d;
  logic                    placed_q, placed_d;
  logic [PositionBits-1:0] ms_q, ms_d, me_q, me_d, prev_end_q, prev_end_d;
  logic [CntW-1:0]         acc_n_q, acc_n_d;
  logic [PositionBits-1:0] acc_tot_q, acc_tot_d, acc_bs_q, acc_bs_d, acc_be_q, acc_be_d;
  logic                    ovf_q, ovf_d, hit_q, hit_d;

  // ram ports
  logic                    ram_we;
  logic [AdrW-1:0]         ram_waddr, ram_raddr;
  logic [EntW-1:0]         ram_wdata, ram_rdata;
  logic [PositionBits-1:0] ent_s, ent_e;

  // step decisions
  logic                    adv, wr, emit_gap, eot, out_free, walk_done;
  logic [PositionBits-1:0] w_s, w_e;

  // output register
  logic                    out_valid_q;
  logic                    o_cov_q, o_gv_q, o_last_q, o_ovf_q, o_rej_q;
  logic [PositionBits-1:0] o_tot_q, o_bs_q, o_be_q, o_gs_q, o_ge_q;
  logic [CntW-1:0]         o_cnt_q;

  icset_ram #(
    .Width(EntW),
    .Depth(2 ** AdrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent_s    = ram_rdata[PositionBits-1:0];
  assign ent_e    = ram_rdata[EntW-1:PositionBits];
  assign eot      = (idx_q == count_q);
  assign out_free = !out_valid_q || out_ready_i;

  // one walk step over the entry at idx_q
  always_comb begin
    adv        = 1'b0;
    wr         = 1'b0;
    emit_gap   = 1'b0;
    w_s        = ent_s;
    w_e        = ent_e;
    placed_d   = placed_q;
    ms_d       = ms_q;
    me_d       = me_q;
    hit_d      = hit_q;
    prev_end_d = prev_end_q;
    walk_done  = 1'b0;
    case (op_q)
      OP_ADD: begin
        walk_done = rej_q || (eot && placed_q);
        if (!rej_q) begin
          if (!eot) begin
            if (placed_q || (ent_e < s_q)) begin
              // entry lies wholly before or after the new interval
              wr  = 1'b1;
              adv = 1'b1;
            end else if (ent_s <= e_q) begin
              // overlapping or touching: absorb into the merged interval
              if (ent_s < ms_q) ms_d = ent_s;
              if (ent_e > me_q) me_d = ent_e;
              adv = 1'b1;
            end else begin
              // merged interval goes in before this entry
              wr       = 1'b1;
              w_s      = ms_q;
              w_e      = me_q;
              placed_d = 1'b1;
            end
          end else if (!placed_q) begin
            wr       = 1'b1;
            w_s      = ms_q;
            w_e      = me_q;
            placed_d = 1'b1;
          end
        end
      end
      OP_PROBE: begin
        walk_done = eot;
        if (!eot) begin
          if ((ent_s <= p_q) && (p_q < ent_e)) hit_d = 1'b1;
          adv = 1'b1;
        end
      end
      OP_GAPS: begin
        walk_done = eot;
        if (!eot) begin
          if (idx_q == '0) begin
            prev_end_d = ent_e;
            adv        = 1'b1;
          end else if (out_free) begin
            emit_gap   = 1'b1;
            prev_end_d = ent_e;
            adv        = 1'b1;
          end
        end
      end
      default: walk_done = 1'b1;
    endcase
    if (!cmd_i.walk) begin
      adv      = 1'b0;
      wr       = 1'b0;
      emit_gap = 1'b0;
    end
  end

  assign status_o.walk_done    = walk_done;
  assign status_o.final_needed = !((op_q == OP_GAPS) && (count_q >= CntW'(2)));
  assign status_o.out_free     = out_free;

  // new table accumulation and read addressing
  always_comb begin
    idx_d     = cmd_i.start ? '0 : idx_q + CntW'(adv);
    ram_raddr = {bank_q, idx_d[IdxW-1:0]};
    ram_waddr = {~bank_q, acc_n_q[IdxW-1:0]};
    ram_wdata = {w_e, w_s};
    ram_we    = 1'b0;
    acc_n_d   = acc_n_q;
    acc_tot_d = acc_tot_q;
    acc_bs_d  = acc_bs_q;
    acc_be_d  = acc_be_q;
    ovf_d     = ovf_q;
    if (wr) begin
      if (acc_n_q == MaxCnt) begin
        ovf_d = 1'b1;
      end else begin
        ram_we    = 1'b1;
        acc_n_d   = acc_n_q + CntW'(1);
        acc_tot_d = acc_tot_q + (w_e - w_s);
        acc_be_d  = w_e;
        if (acc_n_q == '0) acc_bs_d = w_s;
      end
    end
  end

  // commit of the table state
  always_comb begin
    bank_d  = bank_q;
    count_d = count_q;
    total_d = total_q;
    bs_d    = bs_q;
    be_d    = be_q;
    if (cmd_i.commit) begin
      case (op_q)
        OP_ADD: begin
          if (!rej_q && !ovf_q) begin
            bank_d  = ~bank_q;
            count_d = acc_n_q;
            total_d = acc_tot_q;
            bs_d    = acc_bs_q;
            be_d    = acc_be_q;
          end
        end
        OP_CLEAR: begin
          count_d = '0;
          total_d = '0;
          bs_d    = '0;
          be_d    = '0;
        end
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q      <= 1'b0;
      count_q     <= '0;
      total_q     <= '0;
      bs_q        <= '0;
      be_q        <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      bank_q  <= bank_d;
      count_q <= count_d;
      total_q <= total_d;
      bs_q    <= bs_d;
      be_q    <= be_d;
      idx_q   <= idx_d;
      if (emit_gap || cmd_i.emit_final) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // walk payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q      <= op_i;
      s_q       <= interval_start_i;
      e_q       <= interval_end_i;
      p_q       <= probe_position_i;
      rej_q     <= (op_i == OP_ADD) && (interval_end_i <= interval_start_i);
      placed_q  <= 1'b0;
      ms_q      <= interval_start_i;
      me_q      <= interval_end_i;
      acc_n_q   <= '0;
      acc_tot_q <= '0;
      acc_bs_q  <= '0;
      acc_be_q  <= '0;
      ovf_q     <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      placed_q   <= placed_d;
      ms_q       <= ms_d;
      me_q       <= me_d;
      acc_n_q    <= acc_n_d;
      acc_tot_q  <= acc_tot_d;
      acc_bs_q   <= acc_bs_d;
      acc_be_q   <= acc_be_d;
      ovf_q      <= ovf_d;
      hit_q      <= hit_d;
      prev_end_q <= prev_end_d;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (emit_gap || cmd_i.emit_final) begin
      o_tot_q  <= total_q;
      o_cnt_q  <= count_q;
      o_bs_q   <= bs_q;
      o_be_q   <= be_q;
      o_cov_q  <= cmd_i.emit_final && (op_q == OP_PROBE) && hit_q;
      o_gv_q   <= emit_gap;
      o_gs_q   <= emit_gap ? prev_end_q : '0;
      o_ge_q   <= emit_gap ? ent_s : '0;
      o_last_q <= cmd_i.emit_final || (idx_q == count_q - CntW'(1));
      o_ovf_q  <= cmd_i.emit_final && (op_q == OP_ADD) && ovf_q;
      o_rej_q  <= cmd_i.emit_final && rej_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign covered_o      = o_cov_q;
  assign total_length_o = o_tot_q;
  assign entry_count_o  = o_cnt_q;
  assign bound_start_o  = o_bs_q;
  assign bound_end_o    = o_be_q;
  assign gap_valid_o    = o_gv_q;
  assign gap_start_o    = o_gs_q;
  assign gap_end_o      = o_ge_q;
  assign last_o         = o_last_q;
  assign overflow_o     = o_ovf_q;
  assign rejected_o     = o_rej_q;

  // stored entry count never exceeds the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= MaxCnt))
    else $error("icset_dp: entry count beyond depth");

  // stored entries never touch, so every listed gap is non-empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_gv_q) |-> (o_ge_q > o_gs_q))
    else $error("icset_dp: empty gap listed");

  // a new word is never loaded over one that is still stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_gap || cmd_i.emit_final) |-> out_free)
    else $error("icset_dp: result overwritten while stalled");

endmodule
